// ----- src/sia_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insertion array package
// Shared types, codes and constants for the sorted insertion array.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned SIA_DATA_W   = 32;
  localparam int unsigned SIA_CAPACITY = 64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0]            action;
    logic [SIA_DATA_W-1:0] value;
    logic [5:0]            index;
  } sia_in_t;

  typedef struct packed {
    logic [SIA_DATA_W-1:0] read_value;
    logic [1:0]            status;
    logic [6:0]            entry_count;
  } sia_out_t;

  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [SIA_DATA_W-1:0] value;
  } sia_cmd_t;

  typedef enum logic {
    SIA_IDLE,
    SIA_LOOKUP
  } sia_state_e;

endpackage

// ----- src/sia_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insertion array cell
// Holds one entry, compares it with an inserted value and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sia_cell
  import sia_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 7
) (
  input  logic                  clk_i,
  input  sia_cmd_t              cmd_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [IDX_W-1:0]      cnt_i,
  input  logic                  left_lt_i,
  input  logic [SIA_DATA_W-1:0] left_data_i,
  input  logic [SIA_DATA_W-1:0] right_data_i,
  output logic                  lt_o,
  output logic [SIA_DATA_W-1:0] data_o,
  output logic [SIA_DATA_W-1:0] rd_o
);

  localparam logic [IDX_W-1:0] Pos = IDX_W'(IDX);

  logic                  live;
  logic [SIA_DATA_W-1:0] entry_q;
  logic [SIA_DATA_W-1:0] entry_d;

  assign live   = Pos < cnt_i;
  assign lt_o   = live && (entry_q < cmd_i.value);
  assign data_o = entry_q;
  assign rd_o   = (live && (Pos == idx_i)) ? entry_q : '0;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (!lt_o) begin
        entry_d = left_lt_i ? cmd_i.value : left_data_i;
      end
    end else if (cmd_i.rem) begin
      if (Pos >= idx_i) begin
        entry_d = right_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- src/sia_or_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insertion array read tree
// Registered OR tree that gathers the one selected cell output, one level
// per cycle.
// ----------------------------------------------------------------------------
module sia_or_tree
  import sia_pkg::*;
#(
  parameter int unsigned CAPACITY = SIA_CAPACITY,
  parameter int unsigned LEVELS   = 6
) (
  input  logic                                clk_i,
  input  logic [CAPACITY-1:0][SIA_DATA_W-1:0] leaf_i,
  output logic [SIA_DATA_W-1:0]               data_o
);

  localparam int unsigned P = 1 << LEVELS;

  logic [P-1:0][SIA_DATA_W-1:0]             pad;
  logic [LEVELS-1:0][P-1:0][SIA_DATA_W-1:0] stage_q;

  always_comb begin
    pad = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      pad[j] = leaf_i[j];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < P; j++) begin
      if (j < P / 2) begin
        stage_q[0][j] <= pad[2*j] | pad[2*j+1];
      end else begin
        stage_q[0][j] <= '0;
      end
    end
    for (int k = 1; k < LEVELS; k++) begin
      for (int j = 0; j < P; j++) begin
        if (j < (P >> (k + 1))) begin
          stage_q[k][j] <= stage_q[k-1][2*j] | stage_q[k-1][2*j+1];
        end else begin
          stage_q[k][j] <= '0;
        end
      end
    end
  end

  assign data_o = stage_q[LEVELS-1][0];

endmodule

// ----- src/sorted_insertion_array.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insertion array
// Keeps up to CAPACITY unsigned values in ascending order in a chain of
// cells; inserts, looks up and removes entries by index.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Beat
//   in       input      in_valid_i / in_stall_o  action, value, index
//   out      output     out_valid_o / out_stall_i read_value, status, count
//
// An insert, a remove or an unused action needs no wait state; every cell shifts
// in the same cycle. A lookup holds the lookup state while its read passes the
// registered OR tree over the cells, one level per cycle.
// Reset clears the count and the control state only; the entries need no clearing pass.
// in_stall_o is high while a lookup is in flight and while a second result
// waits behind a stalled output beat.
// ----------------------------------------------------------------------------
module sorted_insertion_array
  import sia_pkg::*;
#(
  parameter int unsigned CAPACITY = SIA_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sia_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sia_out_t out_data_o
);

  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned XW     = (CW > 7) ? CW : 7;
  localparam int unsigned LEVELS = $clog2(CAPACITY);
  localparam int unsigned LW     = $clog2(LEVELS + 1);

  sia_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [LW-1:0] lat_q, lat_d;
  sia_out_t meta_q, meta_d;
  sia_out_t out_q, out_d, pend_q, pend_d, res;
  logic out_v_q, out_v_d, pend_v_q, pend_v_d;

  logic in_acc, out_take, done, full, idx_ok;
  logic [XW-1:0] cnt_x, idx_x;
  sia_cmd_t cmd;

  logic [CAPACITY-1:0]                 lt;
  logic [CAPACITY-1:0][SIA_DATA_W-1:0] data;
  logic [CAPACITY-1:0][SIA_DATA_W-1:0] rd;
  logic [SIA_DATA_W-1:0]               tree_data;

  assign cnt_x    = XW'(count_q);
  assign idx_x    = XW'(in_data_i.index);
  assign full     = count_q == CW'(CAPACITY);
  assign idx_ok   = idx_x < cnt_x;
  assign in_stall_o = (state_q != SIA_IDLE) || pend_v_q;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_v_q && !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign cmd.ins   = in_acc && (in_data_i.action == ACT_INSERT) && !full;
  assign cmd.rem   = in_acc && (in_data_i.action == ACT_REMOVE) && idx_ok;
  assign cmd.value = in_data_i.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  left_lt;
    logic [SIA_DATA_W-1:0] left_data;
    logic [SIA_DATA_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_data = in_data_i.value;
    end else begin : g_mid
      assign left_lt   = lt[i-1];
      assign left_data = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner
      assign right_data = data[i+1];
    end
    sia_cell #(
      .IDX   (i),
      .IDX_W (XW)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .idx_i        (idx_x),
      .cnt_i        (cnt_x),
      .left_lt_i    (left_lt),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .lt_o         (lt[i]),
      .data_o       (data[i]),
      .rd_o         (rd[i])
    );
  end

  sia_or_tree #(
    .CAPACITY (CAPACITY),
    .LEVELS   (LEVELS)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (rd),
    .data_o (tree_data)
  );

  always_comb begin
    state_d = state_q;
    lat_d   = lat_q;
    case (state_q)
      SIA_IDLE: begin
        if (in_acc && (in_data_i.action == ACT_LOOKUP)) begin
          state_d = SIA_LOOKUP;
          lat_d   = LW'(LEVELS - 1);
        end
      end
      SIA_LOOKUP: begin
        if (lat_q == '0) begin
          state_d = SIA_IDLE;
        end else begin
          lat_d = lat_q - 1'b1;
        end
      end
      default: begin
        state_d = SIA_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    meta_d  = meta_q;
    done    = 1'b0;
    res     = '0;
    case (state_q)
      SIA_IDLE: begin
        if (cmd.ins) begin
          count_d = count_q + 1'b1;
        end else if (cmd.rem) begin
          count_d = count_q - 1'b1;
        end
        res.entry_count = 7'(count_d);
        if (in_acc) begin
          case (in_data_i.action)
            ACT_INSERT: res.status = full ? ST_FULL : ST_OK;
            ACT_LOOKUP: res.status = idx_ok ? ST_OK : ST_BAD_INDEX;
            ACT_REMOVE: res.status = idx_ok ? ST_OK : ST_BAD_INDEX;
            default:    res.status = ST_OK;
          endcase
          if (in_data_i.action == ACT_LOOKUP) begin
            meta_d = res;
          end else begin
            done = 1'b1;
          end
        end
      end
      SIA_LOOKUP: begin
        res            = meta_q;
        res.read_value = tree_data;
        done           = lat_q == '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    if (!out_v_q || out_take) begin
      if (pend_v_q) begin
        out_d    = pend_q;
        out_v_d  = 1'b1;
        pend_d   = res;
        pend_v_d = done;
      end else begin
        out_d   = res;
        out_v_d = done;
      end
    end else if (done) begin
      pend_d   = res;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIA_IDLE;
      count_q  <= '0;
      lat_q    <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      lat_q    <= lat_d;
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
    out_q  <= out_d;
    pend_q <= pend_d;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> out_v_q)
    else $error("Pending result without an output beat ahead of it.");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + 1'b1)
    else $error("Insert did not raise the entry count.");

  a_lookup_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIA_LOOKUP) |-> !cmd.ins && !cmd.rem)
    else $error("Store changed during a lookup.");
`endif

endmodule
